// ----- rtl/core/itoa_pkg.sv -----
// Shared types, character codes and radix limits for the integer to ASCII converter.
`default_nettype none
package itoa_pkg;

	localparam int unsigned RadixWidth = 6;
	localparam int unsigned CharWidth  = 8;

	localparam logic [CharWidth-1:0]  CH_MINUS  = 8'h2D;
	localparam logic [CharWidth-1:0]  CH_ZERO   = 8'h30;
	localparam logic [CharWidth-1:0]  CH_A      = 8'h61;
	localparam logic [RadixWidth-1:0] DEC_RADIX = 6'd10;
	localparam logic [RadixWidth-1:0] MIN_RADIX = 6'd2;
	localparam logic [RadixWidth-1:0] MAX_RADIX = 6'd36;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SIGN,
		ST_EMIT_RD,
		ST_EMIT_WR
	} state_t;

	function automatic logic [CharWidth-1:0] digit_char(input logic [RadixWidth-1:0] d);
		logic [CharWidth-1:0] c;
		if (d < DEC_RADIX) begin
			c = CH_ZERO + {2'b00, d};
		end else begin
			c = CH_A + {2'b00, d} - {2'b00, DEC_RADIX};
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/itoa_divu.sv -----
// Bit-serial restoring divider of an unsigned value by a radix, one quotient bit per cycle.
`default_nettype none
module itoa_divu #(
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	input  wire logic [VALUE_WIDTH-1:0]              dividend,
	input  wire logic [itoa_pkg::RadixWidth-1:0]     divisor,
	output logic                                     done,
	output logic [VALUE_WIDTH-1:0]                   quotient,
	output logic [itoa_pkg::RadixWidth-1:0]          remainder
);

	localparam int unsigned SW = $clog2(VALUE_WIDTH);
	localparam int unsigned RW = itoa_pkg::RadixWidth;

	logic          busy_q;
	logic          done_q;
	logic [SW-1:0] step_q;
	logic [VALUE_WIDTH-1:0] quot_q;
	logic [RW-1:0] rem_q;
	logic [RW-1:0] div_q;
	logic [RW:0]   trial;
	logic          ge;
	logic [RW:0]   diff;

	always_comb begin
		trial = {rem_q, quot_q[VALUE_WIDTH-1]};
		ge    = trial >= {1'b0, div_q};
		diff  = trial - {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + SW'(1);
				if (step_q == SW'(VALUE_WIDTH - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			div_q  <= divisor;
		end else if (busy_q) begin
			quot_q <= {quot_q[VALUE_WIDTH-2:0], ge};
			rem_q  <= ge ? diff[RW-1:0] : trial[RW-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quot_q;
	assign remainder = rem_q;

endmodule
`default_nettype wire

// ----- rtl/core/integer_to_ascii_radix.sv -----
// Top level: converts an integer to its ASCII digits in a radix from 2 to 36 (others are
// clamped); only radix 10 reads the value as signed and puts out a '-' first. Digits come
// from the shared divider least significant first and are read back from the digit stack
// in reverse, each character through an ST_EMIT_RD and an ST_EMIT_WR state; out_stall
// holds them. in_stall stays high until the last character of an item is loaded.
// Reset clears the sequencer and the output valid; the digit stack needs no clearing.
`default_nettype none
module integer_to_ascii_radix #(
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic signed [VALUE_WIDTH-1:0]         value,
	input  wire logic [itoa_pkg::RadixWidth-1:0]       radix,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic [itoa_pkg::CharWidth-1:0]             char_code,
	output logic                                       last
);

	localparam int unsigned CW = $clog2(VALUE_WIDTH + 1);
	localparam int unsigned AW = $clog2(VALUE_WIDTH);
	localparam int unsigned RW = itoa_pkg::RadixWidth;

	itoa_pkg::state_t state_q, state_d;

	logic [CW-1:0] cnt_q, cnt_d, cnt_m1;
	logic          sign_q, sign_d;
	logic [RW-1:0] radix_q, radix_c;
	logic [RW-1:0] mem [VALUE_WIDTH];
	logic [RW-1:0] rd_data_q;
	logic          in_acc, neg_dec;
	logic [VALUE_WIDTH-1:0] mag_c;
	logic          div_start, div_done;
	logic [VALUE_WIDTH-1:0] div_dividend, div_quot;
	logic [RW-1:0] div_divisor, div_rem;
	logic          mem_we;
	logic          out_free, out_load, out_last_d;
	logic [itoa_pkg::CharWidth-1:0] out_char_d;
	logic          out_valid_q, last_q;
	logic [itoa_pkg::CharWidth-1:0] char_q;

	assign in_acc   = in_valid && !in_stall;
	assign in_stall = (state_q != itoa_pkg::ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign cnt_m1   = cnt_q - CW'(1);

	always_comb begin
		if (radix < itoa_pkg::MIN_RADIX) begin
			radix_c = itoa_pkg::MIN_RADIX;
		end else if (radix > itoa_pkg::MAX_RADIX) begin
			radix_c = itoa_pkg::MAX_RADIX;
		end else begin
			radix_c = radix;
		end
		neg_dec = value[VALUE_WIDTH-1] && (radix_c == itoa_pkg::DEC_RADIX);
		mag_c   = neg_dec ? ($unsigned(~value) + VALUE_WIDTH'(1)) : $unsigned(value);
	end

	itoa_divu #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_divu (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot),
		.remainder(div_rem)
	);

	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		sign_d       = sign_q;
		div_start    = 1'b0;
		div_dividend = div_quot;
		div_divisor  = radix_q;
		mem_we       = 1'b0;
		out_load     = 1'b0;
		out_char_d   = itoa_pkg::digit_char(rd_data_q);
		out_last_d   = (cnt_q == CW'(1));
		unique case (state_q)
			itoa_pkg::ST_IDLE: begin
				div_dividend = mag_c;
				div_divisor  = radix_c;
				if (in_acc) begin
					div_start = 1'b1;
					cnt_d     = '0;
					sign_d    = neg_dec;
					state_d   = itoa_pkg::ST_DIV;
				end
			end
			itoa_pkg::ST_DIV: begin
				if (div_done) begin
					mem_we = 1'b1;
					cnt_d  = cnt_q + CW'(1);
					if (div_quot == '0) begin
						state_d = sign_q ? itoa_pkg::ST_SIGN : itoa_pkg::ST_EMIT_RD;
					end else begin
						div_start = 1'b1;
					end
				end
			end
			itoa_pkg::ST_SIGN: begin
				out_char_d = itoa_pkg::CH_MINUS;
				out_last_d = 1'b0;
				if (out_free) begin
					out_load = 1'b1;
					state_d  = itoa_pkg::ST_EMIT_RD;
				end
			end
			itoa_pkg::ST_EMIT_RD: begin
				state_d = itoa_pkg::ST_EMIT_WR;
			end
			itoa_pkg::ST_EMIT_WR: begin
				if (out_free) begin
					out_load = 1'b1;
					cnt_d    = cnt_m1;
					state_d  = (cnt_q == CW'(1)) ? itoa_pkg::ST_IDLE : itoa_pkg::ST_EMIT_RD;
				end
			end
			default: begin
				state_d = itoa_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= itoa_pkg::ST_IDLE;
			cnt_q       <= '0;
			sign_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			sign_q  <= sign_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			radix_q <= radix_c;
		end
		if (out_load) begin
			char_q <= out_char_d;
			last_q <= out_last_d;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[cnt_q[AW-1:0]] <= div_rem;
		end
		rd_data_q <= mem[cnt_m1[AW-1:0]];
	end

	assign out_valid = out_valid_q;
	assign char_code = char_q;
	assign last      = last_q;

endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
// Self-checking testbench for integer_to_ascii_radix: directed table plus random numbers.
`timescale 1ns / 100ps
module tb_top;

	localparam int ValueWidth  = 32;
	localparam int RandomItems = 136;
	localparam int CycleLimit  = 1500000;

	typedef struct packed {
		logic [itoa_pkg::CharWidth-1:0] code;
		logic                           last;
	} ascii_char_t;

	typedef struct {
		logic [ValueWidth-1:0]           val;
		logic [itoa_pkg::RadixWidth-1:0] base;
		string                           golden;
	} number_row_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            in_valid = 1'b0;
	logic                            in_stall;
	logic signed [ValueWidth-1:0]    value = '0;
	logic [itoa_pkg::RadixWidth-1:0] radix = itoa_pkg::MIN_RADIX;
	logic                            out_valid;
	logic                            out_stall = 1'b0;
	logic [itoa_pkg::CharWidth-1:0]  char_code;
	logic                            last;

	ascii_char_t pending_chars[$];
	number_row_t number_table[25];
	int          items_sent = 0;
	int          chars_checked = 0;
	int          fault_count = 0;
	int          cycle_count = 0;
	int          rx_gap = 0;
	logic        hold_off = 1'b0;

	integer_to_ascii_radix #(.VALUE_WIDTH(ValueWidth)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.value(value),
		.radix(radix),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.char_code(char_code),
		.last(last)
	);

	always #1 clk = ~clk;

	function automatic logic [itoa_pkg::CharWidth-1:0] digit_to_ascii(
			input logic [itoa_pkg::RadixWidth-1:0] d);
		if (d < itoa_pkg::DEC_RADIX) begin
			return itoa_pkg::CH_ZERO + itoa_pkg::CharWidth'(d);
		end
		return itoa_pkg::CH_A + itoa_pkg::CharWidth'(d) -
			itoa_pkg::CharWidth'(itoa_pkg::DEC_RADIX);
	endfunction

	function automatic void predict_chars(input logic [ValueWidth-1:0] v,
			input logic [itoa_pkg::RadixWidth-1:0] r);
		logic [itoa_pkg::RadixWidth-1:0] base;
		logic [ValueWidth-1:0] mag;
		logic [itoa_pkg::RadixWidth-1:0] digits[$];
		int i;
		base = r;
		mag = v;
		if (base < itoa_pkg::MIN_RADIX) base = itoa_pkg::MIN_RADIX;
		if (base > itoa_pkg::MAX_RADIX) base = itoa_pkg::MAX_RADIX;
		if (base == itoa_pkg::DEC_RADIX && v[ValueWidth-1]) begin
			pending_chars.push_back('{code: itoa_pkg::CH_MINUS, last: 1'b0});
			mag = -v;
		end
		do begin
			digits.push_back(itoa_pkg::RadixWidth'(mag % ValueWidth'(base)));
			mag = mag / ValueWidth'(base);
		end while (mag != 0);
		for (i = digits.size() - 1; i >= 0; i--) begin
			pending_chars.push_back('{code: digit_to_ascii(digits[i]), last: (i == 0)});
		end
	endfunction

	function automatic void expect_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++) begin
			pending_chars.push_back('{code: s[i], last: (i == s.len() - 1)});
		end
	endfunction

	function automatic int draw_gap(input bit quiet);
		return quiet ? 0 : $urandom_range(0, 10);
	endfunction

	task automatic send_number(input logic [ValueWidth-1:0] v,
			input logic [itoa_pkg::RadixWidth-1:0] r, input int gap, input string golden);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		value <= v;
		radix <= r;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		if (golden.len() != 0) expect_text(golden);
		else predict_chars(v, r);
		items_sent++;
	endtask

	always @(posedge clk) begin : char_checker
		ascii_char_t want;
		int next_gap;
		next_gap = (rx_gap > 0) ? rx_gap - 1 : 0;
		if (arst_n && out_valid === 1'b1 && !out_stall) begin
			chars_checked++;
			if (pending_chars.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("Unexpected character 0x%02h last=%0b", char_code, last);
			end else begin
				want = pending_chars.pop_front();
				if (char_code !== want.code || last !== want.last) begin
					fault_count++;
					if (fault_count <= 10)
						$display("Character mismatch: expected 0x%02h last=%0b, got 0x%02h last=%0b",
							want.code, want.last, char_code, last);
				end
			end
			next_gap = draw_gap(chars_checked >= 600 && chars_checked < 900);
		end
		rx_gap <= next_gap;
		out_stall <= hold_off || (next_gap != 0);
	end

	initial begin
		wait (items_sent >= 40);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (600) @(posedge clk);
		hold_off <= 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("integer_to_ascii_radix regression: fail");
			$finish;
		end
	end

	initial begin : stimulus
		logic [ValueWidth-1:0] v;
		logic [itoa_pkg::RadixWidth-1:0] r;
		int n;
		number_table = '{
			'{32'd0,         6'd10, "0"},
			'{32'd0,         6'd2,  "0"},
			'{32'h80000000,  6'd10, "-2147483648"},
			'{32'h7FFFFFFF,  6'd10, "2147483647"},
			'{32'hFFFFFFFF,  6'd10, "-1"},
			'{32'hFFFFFFFF,  6'd16, "ffffffff"},
			'{32'hFFFFFFFF,  6'd2,  ""},
			'{32'hFFFFFFFF,  6'd36, ""},
			'{32'h80000000,  6'd16, "80000000"},
			'{32'h80000000,  6'd2,  ""},
			'{32'h7FFFFFFF,  6'd36, ""},
			'{32'd35,        6'd36, "z"},
			'{32'd10,        6'd36, "a"},
			'{32'd255,       6'd16, "ff"},
			'{32'd12345,     6'd10, "12345"},
			'{32'hFFFFCFC7,  6'd10, "-12345"},
			'{32'hFFFFCFC7,  6'd16, "ffffcfc7"},
			'{32'd5,         6'd0,  "101"},
			'{32'd6,         6'd1,  "110"},
			'{32'd35,        6'd63, "z"},
			'{32'd71,        6'd37, "1z"},
			'{32'd8,         6'd3,  "22"},
			'{32'hFFFFFFF8,  6'd8,  ""},
			'{32'd100,       6'd10, "100"},
			'{32'd0,         6'd63, "0"}
		};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (number_table[i])
			send_number(number_table[i].val, number_table[i].base, draw_gap(1'b0),
				number_table[i].golden);
		for (n = 0; n < RandomItems; n++) begin
			case ($urandom_range(0, 5))
				0: v = $urandom;
				1: v = $urandom_range(0, 100);
				2: v = -ValueWidth'($urandom_range(1, 1000));
				3: begin
					case ($urandom_range(0, 4))
						0: v = 32'h80000000;
						1: v = 32'h7FFFFFFF;
						2: v = 32'hFFFFFFFF;
						3: v = 32'd1;
						default: v = 32'd0;
					endcase
				end
				4: v = $urandom >> $urandom_range(0, 31);
				default: v = -($urandom >> $urandom_range(0, 31));
			endcase
			case ($urandom_range(0, 9))
				7: r = itoa_pkg::DEC_RADIX;
				8: r = itoa_pkg::RadixWidth'($urandom_range(0, 63));
				9: r = ($urandom_range(0, 1) == 0) ? itoa_pkg::MIN_RADIX : itoa_pkg::MAX_RADIX;
				default: r = itoa_pkg::RadixWidth'($urandom_range(itoa_pkg::MIN_RADIX,
					itoa_pkg::MAX_RADIX));
			endcase
			send_number(v, r, draw_gap(n >= 60 && n < 90), "");
		end
		@(posedge clk);
		in_valid <= 1'b0;
		while (pending_chars.size() != 0) @(posedge clk);
		repeat (64) @(posedge clk);
		$display("Converted %0d numbers (%0d from the table) into %0d checked characters,",
			items_sent, $size(number_table), chars_checked);
		$display("covering radix 0 to 63, negative decimal values and the 32-bit extremes.");
		if (fault_count == 0 && pending_chars.size() == 0) begin
			$display("integer_to_ascii_radix regression: pass");
		end else begin
			$display("%0d mismatches, %0d characters never seen", fault_count,
				pending_chars.size());
			$display("integer_to_ascii_radix regression: fail");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/itoa_pkg.sv
rtl/core/itoa_divu.sv
rtl/core/integer_to_ascii_radix.sv
dv/tb_top.sv
